// File: design/ntc_pkg.sv
// shared types, constants and tables for the thermistor converter
`default_nettype none
package ntc_pkg;

	localparam int VOLT_W  = 18;
	localparam int RES_W   = 20;
	localparam int CM_W    = 17;
	localparam int BETA_W  = 14;
	localparam int TEMP_W  = 18;
	localparam int CFG_W   = 20;
	localparam int IDX_W   = 3;
	localparam int NUM_W   = 39;
	localparam int P2_W    = 36;
	localparam int LN_W    = 32;
	localparam int LNR_W   = 34;
	localparam int T0_W    = 25;
	localparam int PROD_W  = 60;
	localparam int QT_W    = 44;
	localparam int DS_W    = 45;
	localparam int DEN_W   = 42;
	localparam int NUMER_W = 57;
	localparam int QUOT_W  = 18;
	localparam int BT_W    = 39;
	localparam int ACC_W   = 26;
	localparam int Z_W     = 31;
	localparam int TK_W    = 20;

	localparam logic [LN_W-1:0]   LN2_Q24   = 32'd11629080;
	localparam logic [T0_W-1:0]   T0_Q16    = 25'd19539558;
	localparam logic [TK_W-1:0]   ZERO_C_Q8 = 20'd69926;
	localparam logic signed [TK_W-1:0] TEMP_MAX = 20'sd102400;
	localparam logic signed [TK_W-1:0] TEMP_MIN = -20'sd70000;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_RANGE  = 2'd1;
	localparam logic [1:0] ST_NONPOS = 2'd2;

	localparam logic [IDX_W-1:0] REG_SUPPLY = 3'd0;
	localparam logic [IDX_W-1:0] REG_SERIES = 3'd1;
	localparam logic [IDX_W-1:0] REG_CM     = 3'd2;
	localparam logic [IDX_W-1:0] REG_REF    = 3'd3;
	localparam logic [IDX_W-1:0] REG_BETA   = 3'd4;
	localparam logic [IDX_W-1:0] REG_SIDE   = 3'd5;

	typedef struct packed {
		logic       vld;
		logic [1:0] status;
		logic       sat_hi;
	} side_t;

	// ln(1 + 2^-k) in Q.24
	function automatic logic [ACC_W-1:0] ln_step(input int k);
		logic [ACC_W-1:0] r;
		begin
			case (k)
				1:       r = 26'd6802576;
				2:       r = 26'd3743728;
				3:       r = 26'd1976072;
				4:       r = 26'd1017112;
				5:       r = 26'd516263;
				6:       r = 26'd260117;
				7:       r = 26'd130563;
				8:       r = 26'd65408;
				9:       r = 26'd32736;
				10:      r = 26'd16376;
				11:      r = 26'd8190;
				12:      r = 26'd4096;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

// File: design/ntc_ln.sv
// pipelined natural log of a positive integer, signed Q.24 result
`default_nettype none
module ntc_ln #(
	parameter int IN_W  = 39,
	parameter int STEPS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic [IN_W-1:0]                   x,
	output logic signed [ntc_pkg::LN_W-1:0]        ln
);
	localparam int EW  = $clog2(IN_W);
	localparam int XW  = IN_W + ntc_pkg::Z_W;

	logic [EW-1:0]             e_a;
	logic [IN_W-1:0]           x_a;
	logic [EW-1:0]             e_lz;
	logic [EW-1:0]             e_s [0:STEPS];
	logic [ntc_pkg::Z_W-1:0]   z_s [0:STEPS];
	logic [ntc_pkg::ACC_W-1:0] acc_s [0:STEPS];
	logic [XW-1:0]             xn;
	logic [ntc_pkg::LN_W-1:0]  fin;

	// leading one position
	always_comb begin
		e_lz = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (x[i]) e_lz = EW'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_a <= e_lz;
			x_a <= x;
		end
	end

	// normalize mantissa to q.30
	assign xn = {x_a, {ntc_pkg::Z_W{1'b0}}} << (EW'(IN_W - 1) - e_a);

	always_ff @(posedge clk) begin
		if (en) begin
			e_s[0]   <= e_a;
			z_s[0]   <= xn[XW-1 -: ntc_pkg::Z_W];
			acc_s[0] <= '0;
		end
	end

	// greedy factor stages, one per step
	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic [ntc_pkg::Z_W:0] t;
		assign t = {1'b0, z_s[k-1]} + {1'b0, z_s[k-1] >> k};
		always_ff @(posedge clk) begin
			if (en) begin
				e_s[k] <= e_s[k-1];
				if (!t[ntc_pkg::Z_W]) begin
					z_s[k]   <= t[ntc_pkg::Z_W-1:0];
					acc_s[k] <= acc_s[k-1] + ntc_pkg::ln_step(k);
				end else begin
					z_s[k]   <= z_s[k-1];
					acc_s[k] <= acc_s[k-1];
				end
			end
		end
	end

	always_comb begin
		logic [ntc_pkg::Z_W:0] rem;
		rem = {1'b1, {ntc_pkg::Z_W{1'b0}}} - {1'b0, z_s[STEPS]};
		fin = ntc_pkg::LN_W'(e_s[STEPS]) * ntc_pkg::LN2_Q24 + ntc_pkg::LN2_Q24
			- ntc_pkg::LN_W'(acc_s[STEPS]) - ntc_pkg::LN_W'(rem >> 7);
	end

	always_ff @(posedge clk) begin
		if (en) ln <= $signed(fin);
	end

endmodule
`default_nettype wire

// File: design/ntc_div.sv
// restoring divider pipeline, one quotient bit per stage, with overflow flag
`default_nettype none
module ntc_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic [ntc_pkg::NUMER_W-1:0]    n,
	input  wire logic [ntc_pkg::DEN_W-1:0]      d,
	input  wire ntc_pkg::side_t                 side_in,
	output logic [ntc_pkg::QUOT_W-1:0]          q,
	output ntc_pkg::side_t                      side_out
);
	localparam int QW = ntc_pkg::QUOT_W;
	localparam int CW = ntc_pkg::DEN_W + QW;

	logic [ntc_pkg::NUMER_W-1:0] r_s [0:QW];
	logic [ntc_pkg::DEN_W-1:0]   d_s [0:QW];
	logic [QW-1:0]               q_s [0:QW];
	ntc_pkg::side_t              sd_s [0:QW];
	logic                        ovf;

	// quotient would not fit: saturate later
	assign ovf = CW'(n) >= (CW'(d) << QW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_s[0] <= '0;
		end else if (en) begin
			sd_s[0] <= {side_in.vld, side_in.status, side_in.sat_hi | ovf};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= n;
			d_s[0] <= d;
			q_s[0] <= '0;
		end
	end

	for (genvar j = 1; j <= QW; j++) begin : g_bit
		logic [CW-1:0] trial;
		logic          take;
		assign trial = CW'(d_s[j-1]) << (QW - j);
		assign take  = CW'(r_s[j-1]) >= trial;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sd_s[j] <= '0;
			else if (en) sd_s[j] <= sd_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[j] <= d_s[j-1];
				q_s[j] <= {q_s[j-1][QW-2:0], take};
				r_s[j] <= take ? ntc_pkg::NUMER_W'(CW'(r_s[j-1]) - trial) : r_s[j-1];
			end
		end
	end

	assign q        = q_s[QW];
	assign side_out = sd_s[QW];

endmodule
`default_nettype wire

// File: design/ntc_thermistor_to_celsius_core.sv
// top level: ntc thermistor divider voltage to celsius converter
`default_nettype none
// Converts one divider voltage word (unsigned q2.16 volts) per clock into a
// signed q.8 celsius temperature and a status code, using the beta equation
// with a greedy shift-and-add natural log and a restoring divider. The whole
// datapath is one stall-together pipeline: a new word is taken every cycle
// while out_ready is high. Its stages: three front stages for resistance,
// LOG_TABLE_BITS + 3 for the log units, five for the beta denominator,
// nineteen for the divider, one output register. Configuration registers must
// be written only while no word is in flight; the block does not enforce it.
module ntc_thermistor_to_celsius_core #(
	parameter int LOG_TABLE_BITS = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_wr_en,
	input  wire logic [ntc_pkg::IDX_W-1:0]          cfg_index,
	input  wire logic [ntc_pkg::CFG_W-1:0]          cfg_wdata,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [ntc_pkg::VOLT_W-1:0]         sense_voltage,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [ntc_pkg::TEMP_W-1:0]       temperature,
	output logic [1:0]                              status
);
	localparam int LN_LAT = LOG_TABLE_BITS + 3;

	// configuration registers
	logic [ntc_pkg::VOLT_W-1:0] supply_q;
	logic [ntc_pkg::RES_W-1:0]  series_q;
	logic [ntc_pkg::CM_W-1:0]   cm_q;
	logic [ntc_pkg::RES_W-1:0]  ref_q;
	logic [ntc_pkg::BETA_W-1:0] beta_q;
	logic                       side_q;
	logic [ntc_pkg::BT_W-1:0]   betat0_q;

	logic [ntc_pkg::RES_W-1:0]  rref_eff;
	logic [ntc_pkg::BETA_W-1:0] beta_eff;

	// global advance: the whole pipe moves unless the output word is stuck
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= 18'd216269;
			series_q <= 20'd10000;
			cm_q     <= '0;
			ref_q    <= 20'd10000;
			beta_q   <= 14'd3435;
			side_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ntc_pkg::REG_SUPPLY: supply_q <= cfg_wdata[ntc_pkg::VOLT_W-1:0];
				ntc_pkg::REG_SERIES: series_q <= cfg_wdata[ntc_pkg::RES_W-1:0];
				ntc_pkg::REG_CM:     cm_q     <= cfg_wdata[ntc_pkg::CM_W-1:0];
				ntc_pkg::REG_REF:    ref_q    <= cfg_wdata[ntc_pkg::RES_W-1:0];
				ntc_pkg::REG_BETA:   beta_q   <= cfg_wdata[ntc_pkg::BETA_W-1:0];
				ntc_pkg::REG_SIDE:   side_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// zero reference or beta reads as one
	assign rref_eff = (ref_q == '0) ? ntc_pkg::RES_W'(1) : ref_q;
	assign beta_eff = (beta_q == '0) ? ntc_pkg::BETA_W'(1) : beta_q;

	// beta * t0, refreshed every cycle from the settled configuration
	always_ff @(posedge clk) begin
		betat0_q <= ntc_pkg::BT_W'(beta_eff) * ntc_pkg::BT_W'(ntc_pkg::T0_Q16);
	end

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: capture the voltage word
	logic                       vld_s1;
	logic [ntc_pkg::VOLT_W-1:0] v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) v_s1 <= sense_voltage;
	end

	// stage 2: range check and divider products
	logic                       range_bad;
	logic [ntc_pkg::VOLT_W-1:0] diff;
	logic [ntc_pkg::NUM_W-1:0]  p1;
	logic [ntc_pkg::P2_W-1:0]   p2;
	logic [ntc_pkg::VOLT_W-1:0] den;

	assign range_bad = (v_s1 == '0) || (v_s1 >= supply_q);
	assign diff      = supply_q - v_s1;

	always_comb begin
		if (side_q) begin
			// thermistor on top: (rs + 2 rcm) * (vs - v) / v
			p1  = (ntc_pkg::NUM_W'(series_q) + ntc_pkg::NUM_W'({cm_q, 1'b0}))
				* ntc_pkg::NUM_W'(diff);
			p2  = '0;
			den = v_s1;
		end else begin
			// thermistor at bottom: (rs * v - 2 rcm * (vs - v)) / (vs - v)
			p1  = ntc_pkg::NUM_W'(series_q) * ntc_pkg::NUM_W'(v_s1);
			p2  = ntc_pkg::P2_W'({cm_q, 1'b0}) * ntc_pkg::P2_W'(diff);
			den = diff;
		end
	end

	ntc_pkg::side_t             side_s2;
	logic [ntc_pkg::NUM_W-1:0]  p1_s2;
	logic [ntc_pkg::P2_W-1:0]   p2_s2;
	logic [ntc_pkg::VOLT_W-1:0] den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else if (adv) begin
			side_s2.vld    <= vld_s1;
			side_s2.status <= range_bad ? ntc_pkg::ST_RANGE : ntc_pkg::ST_OK;
			side_s2.sat_hi <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s2  <= p1;
			p2_s2  <= p2;
			den_s2 <= den;
		end
	end

	// stage 3: resistance numerator and its sign check
	logic signed [ntc_pkg::NUM_W:0] num;
	logic                           nonpos;

	assign num    = $signed({1'b0, p1_s2}) - $signed((ntc_pkg::NUM_W + 1)'(p2_s2));
	assign nonpos = num[ntc_pkg::NUM_W] || (num == '0);

	ntc_pkg::side_t             side_s3;
	logic [ntc_pkg::NUM_W-1:0]  num_s3;
	logic [ntc_pkg::VOLT_W-1:0] den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (adv) begin
			side_s3 <= {side_s2.vld,
				(side_s2.status == ntc_pkg::ST_OK && nonpos) ? ntc_pkg::ST_NONPOS
					: side_s2.status,
				side_s2.sat_hi};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s3 <= num[ntc_pkg::NUM_W-1:0];
			den_s3 <= den_s2;
		end
	end

	// three log units run side by side
	logic signed [ntc_pkg::LN_W-1:0] ln_n;
	logic signed [ntc_pkg::LN_W-1:0] ln_d;
	logic signed [ntc_pkg::LN_W-1:0] ln_r;

	ntc_ln #(.IN_W(ntc_pkg::NUM_W), .STEPS(LOG_TABLE_BITS)) u_ln_num (
		.clk (clk),
		.en  (adv),
		.x   (num_s3),
		.ln  (ln_n)
	);

	ntc_ln #(.IN_W(ntc_pkg::VOLT_W), .STEPS(LOG_TABLE_BITS)) u_ln_den (
		.clk (clk),
		.en  (adv),
		.x   (den_s3),
		.ln  (ln_d)
	);

	ntc_ln #(.IN_W(ntc_pkg::RES_W), .STEPS(LOG_TABLE_BITS)) u_ln_ref (
		.clk (clk),
		.en  (adv),
		.x   (rref_eff),
		.ln  (ln_r)
	);

	// sideband travels beside the log units
	ntc_pkg::side_t side_ln_s [0:LN_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LN_LAT; i++) side_ln_s[i] <= '0;
		end else if (adv) begin
			side_ln_s[0] <= side_s3;
			for (int i = 1; i < LN_LAT; i++) side_ln_s[i] <= side_ln_s[i-1];
		end
	end

	// stage 4: ln(r / rref)
	ntc_pkg::side_t                   side_s4;
	logic signed [ntc_pkg::LNR_W-1:0] lnr_s4;

	// stage 5: ln * t0
	ntc_pkg::side_t                    side_s5;
	logic signed [ntc_pkg::PROD_W-1:0] prod_s5;

	// stage 6: truncating shift by 16
	ntc_pkg::side_t                    side_s6;
	logic signed [ntc_pkg::QT_W-1:0]   qt_s6;
	logic signed [ntc_pkg::PROD_W-1:0] trunc_sum;

	// stage 7: beta equation denominator
	ntc_pkg::side_t                   side_s7;
	logic signed [ntc_pkg::DS_W-1:0]  d_s7;

	// stage 8: divider numerator, saturate on non-positive denominator
	ntc_pkg::side_t                   side_s8;
	logic [ntc_pkg::NUMER_W-1:0]      n_s8;
	logic [ntc_pkg::DEN_W-1:0]        d_s8;
	logic                             d_pos;

	assign trunc_sum = prod_s5 + (prod_s5[ntc_pkg::PROD_W-1]
		? ntc_pkg::PROD_W'(16'hFFFF) : '0);
	assign d_pos = !d_s7[ntc_pkg::DS_W-1] && (d_s7 != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
			side_s7 <= '0;
			side_s8 <= '0;
		end else if (adv) begin
			side_s4 <= side_ln_s[LN_LAT-1];
			side_s5 <= side_s4;
			side_s6 <= side_s5;
			side_s7 <= side_s6;
			side_s8 <= {side_s7.vld, side_s7.status, side_s7.sat_hi | !d_pos};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lnr_s4  <= ntc_pkg::LNR_W'(ln_n) - ntc_pkg::LNR_W'(ln_d)
				- ntc_pkg::LNR_W'(ln_r);
			prod_s5 <= ntc_pkg::PROD_W'(lnr_s4)
				* $signed(ntc_pkg::PROD_W'(ntc_pkg::T0_Q16));
			qt_s6   <= ntc_pkg::QT_W'(trunc_sum >>> 16);
			d_s7    <= $signed(ntc_pkg::DS_W'({beta_eff, 24'b0}))
				+ ntc_pkg::DS_W'(qt_s6);
			n_s8    <= ntc_pkg::NUMER_W'({betat0_q, 16'b0})
				+ ntc_pkg::NUMER_W'(d_s7[ntc_pkg::DS_W-1:1]);
			d_s8    <= d_s7[ntc_pkg::DEN_W-1:0];
		end
	end

	// kelvin in q.8, rounded
	logic [ntc_pkg::QUOT_W-1:0] kel;
	ntc_pkg::side_t             side_dv;

	ntc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.n        (n_s8),
		.d        (d_s8),
		.side_in  (side_s8),
		.q        (kel),
		.side_out (side_dv)
	);

	// celsius and saturation
	logic signed [ntc_pkg::TK_W-1:0] tc;
	logic signed [ntc_pkg::TK_W-1:0] tsat;

	always_comb begin
		tc = $signed(ntc_pkg::TK_W'(kel) - ntc_pkg::ZERO_C_Q8);
		if (side_dv.status != ntc_pkg::ST_OK)  tsat = '0;
		else if (side_dv.sat_hi)              tsat = ntc_pkg::TEMP_MAX;
		else if (tc > ntc_pkg::TEMP_MAX)      tsat = ntc_pkg::TEMP_MAX;
		else if (tc < ntc_pkg::TEMP_MIN)      tsat = ntc_pkg::TEMP_MIN;
		else                                  tsat = tc;
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= side_dv.vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temperature <= tsat[ntc_pkg::TEMP_W-1:0];
			status      <= side_dv.status;
		end
	end

endmodule
`default_nettype wire

// File: tb/sv/ntc_thermistor_to_celsius_core_tb.sv
// testbench for the thermistor voltage to celsius converter
`default_nettype none
module ntc_thermistor_to_celsius_core_tb;

	localparam int LOG_BITS = 8;
	// pipeline depth of the top level
	localparam int PIPE_LAT = LOG_BITS + 31;

	// clock and reset
	logic clk;
	logic arst_n;

	// configuration write port
	logic                       cfg_wr_en;
	logic [ntc_pkg::IDX_W-1:0]  cfg_index;
	logic [ntc_pkg::CFG_W-1:0]  cfg_wdata;

	// input channel
	logic                       in_valid;
	logic                       in_ready;
	logic [ntc_pkg::VOLT_W-1:0] sense_voltage;

	// output channel
	logic                              out_valid;
	logic                              out_ready;
	logic signed [ntc_pkg::TEMP_W-1:0] temperature;
	logic [1:0]                        status;

	// one expected output word
	typedef struct {
		logic signed [ntc_pkg::TEMP_W-1:0] temp;
		logic [1:0]                        stat;
	} reading_t;

	// local copy of the register file
	logic [ntc_pkg::VOLT_W-1:0] sup_v;
	logic [ntc_pkg::RES_W-1:0]  ser_r;
	logic [ntc_pkg::CM_W-1:0]   cm_r;
	logic [ntc_pkg::RES_W-1:0]  ref_r;
	logic [ntc_pkg::BETA_W-1:0] beta_k;
	logic                       side_top;

	reading_t pending_readings[$];
	int       error_count;
	bit       stim_done;

	// directed rows: voltage, whether the result is typed in, expected result
	typedef struct {
		logic [ntc_pkg::VOLT_W-1:0]        volt;
		bit                                known;
		logic signed [ntc_pkg::TEMP_W-1:0] temp;
		logic [1:0]                        stat;
	} vector_t;

	ntc_thermistor_to_celsius_core #(.LOG_TABLE_BITS(LOG_BITS)) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sense_voltage (sense_voltage),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.temperature   (temperature),
		.status        (status)
	);

	// 12 unit period
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// natural log of a positive integer, signed q.24, shift-and-add
	function automatic longint ln_fixed(input longint unsigned x);
		int             msb;
		longint unsigned mant;
		longint unsigned grown;
		longint         acc;
		longint         steps[12];
		begin
			steps = '{6802576, 3743728, 1976072, 1017112, 516263, 260117,
				130563, 65408, 32736, 16376, 8190, 4096};
			if (x == 0)
				return 0;
			msb = 63;
			while (msb > 0 && x[msb] == 1'b0)
				msb--;
			mant = (msb >= 30) ? (x >> (msb - 30)) : (x << (30 - msb));
			acc = 0;
			for (int k = 1; k <= LOG_BITS && k <= 12; k++) begin
				grown = mant + (mant >> k);
				if (grown < (64'd1 << 31)) begin
					mant = grown;
					acc += steps[k-1];
				end
			end
			acc += longint'(((64'd1 << 31) - mant) >> 7);
			return longint'(msb) * 11629080 + 11629080 - acc;
		end
	endfunction

	// beta equation temperature for one voltage word under current settings
	function automatic reading_t convert_voltage(input logic [ntc_pkg::VOLT_W-1:0] volt);
		reading_t r;
		longint   rref, beta, num, den, lnr, dsum, kel, t, diff;
		begin
			r.temp = '0;
			r.stat = ntc_pkg::ST_OK;
			rref = (ref_r == 0) ? 1 : longint'(ref_r);
			beta = (beta_k == 0) ? 1 : longint'(beta_k);
			// voltage zero or at/above supply
			if (volt == 0 || volt >= sup_v) begin
				r.stat = ntc_pkg::ST_RANGE;
				return r;
			end
			diff = longint'(sup_v) - longint'(volt);
			if (!side_top) begin
				num = longint'(ser_r) * longint'(volt) - 2 * longint'(cm_r) * diff;
				den = diff;
			end else begin
				num = (longint'(ser_r) + 2 * longint'(cm_r)) * diff;
				den = longint'(volt);
			end
			if (num <= 0) begin
				r.stat = ntc_pkg::ST_NONPOS;
				return r;
			end
			lnr = ln_fixed(num) - ln_fixed(den) - ln_fixed(rref);
			dsum = beta * (longint'(1) << 24) + (lnr * 19539558) / 65536;
			// non-positive denominator saturates hot
			if (dsum <= 0)
				t = 102400;
			else begin
				kel = (beta * 19539558 * 65536 + dsum / 2) / dsum;
				t = kel - 69926;
				if (t > 102400)
					t = 102400;
				if (t < -70000)
					t = -70000;
			end
			r.temp = t[ntc_pkg::TEMP_W-1:0];
			return r;
		end
	endfunction

	task automatic report_mismatch(input string what);
		begin
			$display("mismatch: %s", what);
			error_count++;
		end
	endtask

	// register write, mirrored into the local copy; the port is left idle before the task returns
	task automatic write_reg(input logic [ntc_pkg::IDX_W-1:0] idx,
		input logic [ntc_pkg::CFG_W-1:0] val);
		begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx;
			cfg_wdata <= val;
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			case (idx)
				ntc_pkg::REG_SUPPLY: sup_v    = val[ntc_pkg::VOLT_W-1:0];
				ntc_pkg::REG_SERIES: ser_r    = val[ntc_pkg::RES_W-1:0];
				ntc_pkg::REG_CM:     cm_r     = val[ntc_pkg::CM_W-1:0];
				ntc_pkg::REG_REF:    ref_r    = val[ntc_pkg::RES_W-1:0];
				ntc_pkg::REG_BETA:   beta_k   = val[ntc_pkg::BETA_W-1:0];
				ntc_pkg::REG_SIDE:   side_top = val[0];
				default: ;
			endcase
			@(posedge clk);
		end
	endtask

	task automatic load_settings(input int sv, input int sr, input int cm,
		input int rr, input int bk, input int sd);
		begin
			write_reg(ntc_pkg::REG_SUPPLY, ntc_pkg::CFG_W'(sv));
			write_reg(ntc_pkg::REG_SERIES, ntc_pkg::CFG_W'(sr));
			write_reg(ntc_pkg::REG_CM, ntc_pkg::CFG_W'(cm));
			write_reg(ntc_pkg::REG_REF, ntc_pkg::CFG_W'(rr));
			write_reg(ntc_pkg::REG_BETA, ntc_pkg::CFG_W'(bk));
			write_reg(ntc_pkg::REG_SIDE, ntc_pkg::CFG_W'(sd));
		end
	endtask

	// send one word, queueing its expected reading; wait a random gap first
	task automatic send_word(input logic [ntc_pkg::VOLT_W-1:0] volt);
		int gap;
		begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pending_readings.push_back(convert_voltage(volt));
			in_valid      <= 1'b1;
			sense_voltage <= volt;
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
		end
	endtask

	// all results back, then let the pipeline drain before a register write
	task automatic wait_idle;
		begin
			in_valid <= 1'b0;
			while (pending_readings.size() != 0)
				@(posedge clk);
			repeat (PIPE_LAT + 5) @(posedge clk);
		end
	endtask

	// random voltage mostly inside the supply, sometimes at edges or outside
	function automatic logic [ntc_pkg::VOLT_W-1:0] pick_voltage();
		int sel;
		begin
			sel = $urandom_range(0, 19);
			if (sel == 0)
				return '0;
			if (sel == 1)
				return sup_v;
			if (sel == 2)
				return ntc_pkg::VOLT_W'($urandom_range(0, 262143));
			if (sel == 3)
				return '1;
			if (sup_v <= 1)
				return ntc_pkg::VOLT_W'($urandom_range(0, 262143));
			return ntc_pkg::VOLT_W'($urandom_range(1, sup_v - 1));
		end
	endfunction

	// result side: random stall per word, compare against oldest expectation
	initial begin
		int       stall;
		reading_t exp_r;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			// word accepted at this edge
			if (pending_readings.size() == 0)
				report_mismatch("output word with nothing expected");
			else begin
				exp_r = pending_readings.pop_front();
				if (temperature !== exp_r.temp)
					report_mismatch($sformatf("temperature %0d, expected %0d",
						temperature, exp_r.temp));
				if (status !== exp_r.stat)
					report_mismatch($sformatf("status %0d, expected %0d",
						status, exp_r.stat));
			end
		end
	end

	// stimulus
	initial begin
		vector_t vectors[$];
		vector_t row;
		reading_t got;
		error_count   = 0;
		stim_done     = 1'b0;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		sense_voltage = '0;
		// reset values of the register file
		sup_v = 18'd216269; ser_r = 20'd10000; cm_r = '0;
		ref_r = 20'd10000; beta_k = 14'd3435; side_top = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under reset settings; known rows are easy reads
		vectors = '{
			'{18'd0,      1'b1, 18'sd0,      ntc_pkg::ST_RANGE},   // zero volts
			'{18'd216269, 1'b1, 18'sd0,      ntc_pkg::ST_RANGE},   // at supply
			'{18'h3FFFF,  1'b1, 18'sd0,      ntc_pkg::ST_RANGE},   // full scale
			'{18'd216268, 1'b0, 18'sd0,      ntc_pkg::ST_OK},      // just under supply
			'{18'd1,      1'b0, 18'sd0,      ntc_pkg::ST_OK},      // smallest voltage
			'{18'd108134, 1'b0, 18'sd0,      ntc_pkg::ST_OK},      // mid: near 25 C
			'{18'd108135, 1'b0, 18'sd0,      ntc_pkg::ST_OK},
			'{18'd50000,  1'b0, 18'sd0,      ntc_pkg::ST_OK},
			'{18'd170000, 1'b0, 18'sd0,      ntc_pkg::ST_OK},
			'{18'd131071, 1'b0, 18'sd0,      ntc_pkg::ST_OK},
			'{18'd131072, 1'b0, 18'sd0,      ntc_pkg::ST_OK},
			'{18'd2,      1'b0, 18'sd0,      ntc_pkg::ST_OK}
		};
		foreach (vectors[i]) begin
			row = vectors[i];
			got = convert_voltage(row.volt);
			// typed-in rows checked against the predictor once, as a sanity tie
			if (row.known && row.stat != ntc_pkg::ST_OK && (got.stat !== row.stat
				|| got.temp !== row.temp))
				report_mismatch($sformatf("table row %0d disagrees", i));
			send_word(row.volt);
		end
		wait_idle();

		// top side with common-mode resistor, zero reference and beta read as 1
		load_settings(216269, 10000, 100000, 0, 0, 1);
		foreach (vectors[i])
			send_word(vectors[i].volt);
		wait_idle();

		// bottom side with big common-mode: resistance not positive except near supply
		load_settings(262143, 1, 100000, 1000000, 10000, 0);
		send_word(18'd1);
		send_word(18'd262142);
		send_word(18'd131072);
		wait_idle();

		// large extremes: big series resistor, unit reference, small beta
		load_settings(262143, 1000000, 0, 1, 1000, 0);
		send_word(18'd1);
		send_word(18'd262142);
		send_word(18'd100);
		wait_idle();

		// random phases across several settings
		for (int phase = 0; phase < 8; phase++) begin
			load_settings($urandom_range(1, 262143), $urandom_range(0, 1048575),
				($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 131071),
				$urandom_range(0, 1048575), $urandom_range(0, 16383),
				$urandom_range(0, 1));
			// unknown index must be ignored
			write_reg(ntc_pkg::IDX_W'(6 + $urandom_range(0, 1)),
				ntc_pkg::CFG_W'($urandom));
			repeat (50) send_word(pick_voltage());
			wait_idle();
		end
		stim_done = 1'b1;
	end

	// end of run
	initial begin
		wait (stim_done);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// limit: ~500 words, random gaps and stalls, pipeline drains
	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
